>>> sv/pscg_pkg.sv
// ----------------------------------------------------------------------------
// pscg_pkg
// Shared types, constants and the equal-tempered note table of the pitch
// snap-and-glide corrector.
// ----------------------------------------------------------------------------
`default_nettype none

package pscg_pkg;

    localparam int PITCH_W    = 16;
    localparam int COEF_W     = 16;
    localparam int NOTE_COUNT = 60;
    localparam int IDX_W      = $clog2(NOTE_COUNT);
    localparam int A4_INDEX   = 49;
    localparam int CHANGE_LIM = 16;
    localparam int ADDR_W     = 3;

    localparam logic [PITCH_W-1:0] PITCH_MAX = {PITCH_W{1'b1}};
    localparam logic [PITCH_W-1:0] PITCH_A4  = PITCH_W'(7040);
    localparam logic [COEF_W-1:0]  STRENGTH_RST = COEF_W'(32768);
    localparam logic [COEF_W-1:0]  GLIDE_RST    = COEF_W'(3277);

    // register index codes (paddr[2])
    localparam logic REG_STRENGTH = 1'b0;
    localparam logic REG_GLIDE    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GMUL,
        ST_GADD,
        ST_SMUL,
        ST_SADD
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic take_in;
        logic scan_start;
        logic load_target;
        logic mac_load;
        logic sel_str;
        logic load_cur;
        logic load_out;
    } t_ctrl;

    typedef logic [PITCH_W-1:0] t_note_rom [NOTE_COUNT];

    // 2^(k/12) in Q24
    localparam longint unsigned SEMI_Q24 [12] = '{
        64'd16777216, 64'd17774841, 64'd18831788, 64'd19951585,
        64'd21137968, 64'd22394897, 64'd23726566, 64'd25137421,
        64'd26632170, 64'd28215802, 64'd29893600, 64'd31671166
    };

    // Note n = round(55 * 2^((n-49)/12) * 2^7), Q24 ratio, round half up.
    function automatic t_note_rom f_note_rom();
        t_note_rom         rom;
        int                s;
        int                oct;
        int                k;
        int                sh;
        longint unsigned   prod;
        longint unsigned   v;
        for (int n = 0; n < NOTE_COUNT; n++) begin
            s   = n - A4_INDEX;
            oct = (s >= 0) ? (s / 12) : -((-s + 11) / 12);
            k   = s - 12 * oct;
            sh  = oct + 7;
            if (sh < 0) sh = 0;
            if (sh > 30) sh = 30;
            prod = 64'd55 * SEMI_Q24[k];
            v    = ((prod << sh) + (64'd1 << 23)) >> 24;
            rom[n] = (v > 64'(PITCH_MAX)) ? PITCH_MAX : v[PITCH_W-1:0];
        end
        return rom;
    endfunction

    localparam t_note_rom NOTE_ROM = f_note_rom();

endpackage

`default_nettype wire

>>> sv/pscg_scan.sv
// ----------------------------------------------------------------------------
// pscg_scan
// Nearest-note search: one note table entry compared per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pscg_scan
    import pscg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [PITCH_W-1:0] i_pitch,
    output logic                    o_done,
    output logic [PITCH_W-1:0]      o_note
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NOTE_COUNT - 1);

    logic               r_busy;
    logic               r_done;
    logic [IDX_W-1:0]   r_idx;
    logic [PITCH_W-1:0] r_pc;
    logic [PITCH_W-1:0] r_best;
    logic [PITCH_W-1:0] r_best_dist;

    logic [PITCH_W-1:0] n_pc;
    logic [PITCH_W-1:0] note;
    logic [PITCH_W:0]   diff;
    logic [PITCH_W-1:0] note_dist;
    logic               take;

    // clamp to the table range
    always_comb begin
        n_pc = i_pitch;
        if (i_pitch < NOTE_ROM[0]) n_pc = NOTE_ROM[0];
        if (i_pitch > NOTE_ROM[NOTE_COUNT-1]) n_pc = NOTE_ROM[NOTE_COUNT-1];
    end

    // strict compare: lower note wins a tie
    always_comb begin
        note      = NOTE_ROM[r_idx];
        diff      = {1'b0, r_pc} - {1'b0, note};
        note_dist = diff[PITCH_W] ? PITCH_W'(-diff) : diff[PITCH_W-1:0];
        take      = (r_idx == '0) || (note_dist < r_best_dist);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (r_idx == IDX_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) r_pc <= n_pc;
        if (r_busy && take) begin
            r_best      <= note;
            r_best_dist <= note_dist;
        end
    end

    assign o_done = r_done;
    assign o_note = r_best;

endmodule

`default_nettype wire

>>> sv/pscg_mac.sv
// ----------------------------------------------------------------------------
// pscg_mac
// Shared move unit: base + floor(coef * (other - base) / 2^15), saturated.
// Product registered; sum formed combinationally from the held product.
// ----------------------------------------------------------------------------
`default_nettype none

module pscg_mac
    import pscg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire logic [PITCH_W-1:0] i_base,
    input  wire logic [PITCH_W-1:0] i_other,
    input  wire logic [COEF_W-1:0]  i_coef,
    output logic [PITCH_W-1:0]      o_result
);

    localparam int PROD_W = PITCH_W + COEF_W + 2;
    localparam int SHF_W  = PROD_W - 15;
    localparam int SUM_W  = SHF_W + 2;

    logic signed [PITCH_W:0]   diff;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   sum;

    always_comb begin
        diff   = $signed({1'b0, i_other}) - $signed({1'b0, i_base});
        n_prod = PROD_W'(diff * $signed({1'b0, i_coef}));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_prod <= n_prod;
    end

    // arithmetic shift floors toward minus infinity
    always_comb begin
        sum = $signed(SUM_W'({1'b0, i_base}))
            + SUM_W'($signed(r_prod[PROD_W-1:15]));
        if (sum < 0)
            o_result = '0;
        else if (sum > $signed(SUM_W'({1'b0, PITCH_MAX})))
            o_result = PITCH_MAX;
        else
            o_result = sum[PITCH_W-1:0];
    end

endmodule

`default_nettype wire

>>> sv/pscg_fsm.sv
// ----------------------------------------------------------------------------
// pscg_fsm
// Sequencer: intake, note search, glide move, strength blend, output.
// ----------------------------------------------------------------------------
`default_nettype none

module pscg_fsm
    import pscg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_changed,
    input  wire logic i_scan_done,
    input  wire logic i_out_free,
    output t_ctrl     o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = i_changed ? ST_SCAN : ST_GMUL;
            end
            ST_SCAN: begin
                if (i_scan_done) n_state = ST_GMUL;
            end
            ST_GMUL: n_state = ST_GADD;
            ST_GADD: n_state = ST_SMUL;
            ST_SMUL: n_state = ST_SADD;
            ST_SADD: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            ST_IDLE: begin
                o_ctrl.in_ready   = 1'b1;
                o_ctrl.take_in    = i_in_valid;
                o_ctrl.scan_start = i_in_valid && i_changed;
            end
            ST_SCAN: o_ctrl.load_target = i_scan_done;
            ST_GMUL: o_ctrl.mac_load    = 1'b1;
            ST_GADD: o_ctrl.load_cur    = 1'b1;
            ST_SMUL: begin
                o_ctrl.sel_str  = 1'b1;
                o_ctrl.mac_load = 1'b1;
            end
            ST_SADD: begin
                o_ctrl.sel_str  = 1'b1;
                o_ctrl.load_out = i_out_free;
            end
            default: o_ctrl = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/pitch_snap_glide_corrector.sv
// ----------------------------------------------------------------------------
// pitch_snap_glide_corrector
// Snaps a detected pitch toward the nearest equal-tempered note with a glide
// and blends the result with the input by a strength factor.
// ----------------------------------------------------------------------------
// Flow: an input is taken while idle; when it moved by more than 1 Hz the note
//   table is searched, one entry per cycle in the scan unit, then the glide
//   move and the strength blend run and the result is loaded for output.
// Intake: one item at a time, no new input before the last is done; next input
//   taken once the result is in the output register, so a held result does
//   not block the next intake.
// Reset (synchronous, i_rst_n low): current/target 7040 (A4), last accepted 0,
//   strength 32768, glide 3277, no result pending.
`default_nettype none

module pitch_snap_glide_corrector
    import pscg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [PITCH_W-1:0] i_pitch_in,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [PITCH_W-1:0]      o_pitch_out,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while idle; the block itself does not enforce it.
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] r_strength;
    logic [COEF_W-1:0] r_glide;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= STRENGTH_RST;
            r_glide    <= GLIDE_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_STRENGTH: r_strength <= pwdata[COEF_W-1:0];
                REG_GLIDE:    r_glide    <= pwdata[COEF_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_STRENGTH: prdata = 32'(r_strength);
            REG_GLIDE:    prdata = 32'(r_glide);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pitch state
    // ------------------------------------------------------------------
    t_ctrl              ctrl;
    logic [PITCH_W-1:0] r_pitch;     // item being worked on
    logic [PITCH_W-1:0] r_last;      // last accepted (moved) input
    logic [PITCH_W-1:0] r_current;
    logic [PITCH_W-1:0] r_target;
    logic [PITCH_W-1:0] r_pitch_out;
    logic               r_out_valid;

    logic [PITCH_W:0]   chg_diff;
    logic [PITCH_W-1:0] chg_abs;
    logic               changed;
    logic               out_free;
    logic               scan_done;
    logic [PITCH_W-1:0] scan_note;
    logic [PITCH_W-1:0] mac_base;
    logic [PITCH_W-1:0] mac_other;
    logic [COEF_W-1:0]  mac_coef;
    logic [PITCH_W-1:0] mac_result;

    // change test: move must exceed 1 Hz strictly
    always_comb begin
        chg_diff = {1'b0, i_pitch_in} - {1'b0, r_last};
        chg_abs  = chg_diff[PITCH_W] ? PITCH_W'(-chg_diff) : chg_diff[PITCH_W-1:0];
        changed  = chg_abs > PITCH_W'(CHANGE_LIM);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_current <= PITCH_A4;
            r_target  <= PITCH_A4;
        end else begin
            if (ctrl.take_in && changed) r_last    <= i_pitch_in;
            if (ctrl.load_target)        r_target  <= scan_note;
            if (ctrl.load_cur)           r_current <= mac_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.take_in)  r_pitch     <= i_pitch_in;
        if (ctrl.load_out) r_pitch_out <= mac_result;
    end

    // output register: a held result does not block the next intake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (ctrl.load_out)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared move unit: glide pass moves current toward target, strength
    // pass blends the input toward the new current.
    // ------------------------------------------------------------------
    always_comb begin
        if (ctrl.sel_str) begin
            mac_base  = r_pitch;
            mac_other = r_current;
            mac_coef  = r_strength;
        end else begin
            mac_base  = r_current;
            mac_other = r_target;
            mac_coef  = r_glide;
        end
    end

    pscg_mac u_mac (
        .i_clk    (i_clk),
        .i_load   (ctrl.mac_load),
        .i_base   (mac_base),
        .i_other  (mac_other),
        .i_coef   (mac_coef),
        .o_result (mac_result)
    );

    pscg_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.scan_start),
        .i_pitch (i_pitch_in),
        .o_done  (scan_done),
        .o_note  (scan_note)
    );

    pscg_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_changed   (changed),
        .i_scan_done (scan_done),
        .i_out_free  (out_free),
        .o_ctrl      (ctrl)
    );

    assign o_in_stall  = !ctrl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_pitch_out = r_pitch_out;

endmodule

`default_nettype wire
